// ===== rtl/core/swm_pkg.sv =====
// Shared widths, constants and link types for the sliding window median filter.
`default_nettype none
package swm_pkg;

	localparam int SMP_W      = 16;
	localparam int AGE_W      = 4;
	localparam int CNT_W      = 4;
	localparam int WINDOW_DEF = 9;

	// One window entry: sample value plus its age tag (0 = oldest).
	typedef struct packed {
		logic signed [SMP_W-1:0] value;
		logic [AGE_W-1:0]        age;
	} swm_ent_t;

	// Controls broadcast to every cell for the current word.
	typedef struct packed {
		logic                    load;
		logic                    full;
		logic signed [SMP_W-1:0] sample;
		logic [AGE_W-1:0]        ins_age;
		logic [CNT_W-1:0]        len;
	} swm_bcast_t;

	// Link handed from a cell to its right neighbor.
	typedef struct packed {
		swm_ent_t t_ent;
		logic     t_valid;
		logic     t_le;
		logic     found;
	} swm_link_t;

endpackage
`default_nettype wire

// ===== rtl/core/swm_cell.sv =====
// One window cell: holds a sorted entry and does compare-and-shift with its neighbors.
`default_nettype none
module swm_cell #(
	parameter int WINDOW = swm_pkg::WINDOW_DEF,
	parameter int IDX    = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  swm_pkg::swm_bcast_t bc,
	input  swm_pkg::swm_link_t  left,
	input  swm_pkg::swm_ent_t   right_ent,
	output swm_pkg::swm_ent_t   cur,
	output swm_pkg::swm_ent_t   nxt,
	output swm_pkg::swm_link_t  link
);

	localparam bit IS_LAST  = (IDX == WINDOW - 1);
	localparam bit IS_FIRST = (IDX == 0);

	swm_pkg::swm_ent_t ent_q;
	swm_pkg::swm_ent_t t_ent;
	logic              found;
	logic              t_valid;
	logic              t_le;

	assign cur = ent_q;

	// Removal point is at or left of this cell.
	assign found = left.found | (ent_q.age == '0) | IS_LAST;

	// Window after the oldest entry is dropped (full mode), ages aged by one.
	always_comb begin
		if (bc.full) begin
			t_ent     = found ? right_ent : ent_q;
			t_ent.age = t_ent.age - swm_pkg::AGE_W'(1);
		end else begin
			t_ent = ent_q;
		end
	end

	assign t_valid = bc.full ? !IS_LAST : (swm_pkg::CNT_W'(IDX) < bc.len);
	assign t_le    = t_valid && ($signed(t_ent.value) <= $signed(bc.sample));

	// Insert after equal values: keep, take the sample, or shift from the left.
	always_comb begin
		if (t_le) begin
			nxt = t_ent;
		end else if (IS_FIRST || left.t_le) begin
			nxt.value = bc.sample;
			nxt.age   = bc.ins_age;
		end else if (left.t_valid) begin
			nxt = left.t_ent;
		end else begin
			nxt = ent_q;
		end
	end

	assign link.t_ent   = t_ent;
	assign link.t_valid = t_valid;
	assign link.t_le    = t_le;
	assign link.found   = found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (bc.load) begin
			ent_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sliding_window_median.sv =====
// Top level of the sliding window median filter: cell chain, fill control, output register.
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+------------------------------
//  input   | in_valid, in_stall, sample, action | in      | one sample, push or restart
//  output  | out_valid, out_stall, median     | out       | median of the current window
//
// One word per cycle unless in_stall holds the input: every cell compares and shifts
// in parallel, so an accepted sample updates the whole sorted window in the cycle it is taken.
// The median shows in the cycle after the word that fills or advances the window;
// the first WINDOW-1 samples after reset or restart give no word.
// Input stalls only while a median sits in the output register and the output stalls.
// arst_n clears the window, age tags, fill count and the output valid.
`default_nettype none
module sliding_window_median #(
	parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire signed [swm_pkg::SMP_W-1:0]  sample,
	input  wire                              action,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic signed [swm_pkg::SMP_W-1:0] median
);

	localparam int MID = WINDOW >> 1;

	swm_pkg::swm_bcast_t bc;
	swm_pkg::swm_link_t  links [WINDOW+1];
	swm_pkg::swm_ent_t   cur   [WINDOW+1];
	swm_pkg::swm_ent_t   nxt   [WINDOW];
	logic [WINDOW-1:0]   zero_age;

	logic [swm_pkg::CNT_W-1:0] fill_q;
	logic [swm_pkg::CNT_W-1:0] len;
	logic                      accept;
	logic                      emit;
	logic                      out_valid_q;
	logic signed [swm_pkg::SMP_W-1:0] median_q;

	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign median    = median_q;

	// Restart discards the old fill.
	assign len = action ? '0 : fill_q;

	always_comb begin
		bc.load    = accept;
		bc.full    = (len >= swm_pkg::CNT_W'(WINDOW));
		bc.sample  = sample;
		bc.ins_age = bc.full ? swm_pkg::AGE_W'(WINDOW - 1) : swm_pkg::AGE_W'(len);
		bc.len     = len;
	end

	assign emit = bc.full || (len == swm_pkg::CNT_W'(WINDOW - 1));

	// Chain ends: nothing found or valid to the left, zeros to the right.
	assign links[0] = '0;
	assign cur[WINDOW] = '0;

	for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
		swm_cell #(
			.WINDOW (WINDOW),
			.IDX    (gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bc        (bc),
			.left      (links[gi]),
			.right_ent (cur[gi+1]),
			.cur       (cur[gi]),
			.nxt       (nxt[gi]),
			.link      (links[gi+1])
		);
		assign zero_age[gi] = (cur[gi].age == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (!bc.full) begin
				fill_q <= len + swm_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			median_q <= nxt[MID].value;
		end
	end

	// Fill count never runs past the window size.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= swm_pkg::CNT_W'(WINDOW))
		else $error("fill count beyond window");

	// A full window holds exactly one oldest entry.
	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == swm_pkg::CNT_W'(WINDOW)) |-> $onehot(zero_age))
		else $error("full window without a single oldest entry");

	// A restart leaves exactly one sample in the fill.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action && (WINDOW > 1)) |=> (fill_q == swm_pkg::CNT_W'(1)))
		else $error("restart did not begin a new fill");

	// A result word only follows an accepted sample or a held result.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept))
		else $error("median word without an accepted sample");

endmodule
`default_nettype wire
